/* hdl/hmp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP message parser package
// Shared types, character constants and the per-byte parsing functions.
// ----------------------------------------------------------------------------
package hmp_pkg;

	localparam int HMP_MAX_RESULTS = 3;
	localparam int HMP_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] TAG_NAME  = 3'd3;
	localparam logic [2:0] TAG_VALUE = 3'd4;
	localparam logic [2:0] TAG_BODY  = 3'd5;

	localparam logic [35:0] CODE_LIMIT_POS = 36'd2147483647;
	localparam logic [35:0] CODE_LIMIT_NEG = 36'd2147483648;

	typedef enum logic [1:0] {
		PH_START,
		PH_HEADERS,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		CS_LEAD,
		CS_SIGN,
		CS_DIGITS,
		CS_STOP
	} code_stage_t;

	typedef enum logic [2:0] {
		ERR_OK,
		ERR_NO_CRLF,
		ERR_NO_SP1,
		ERR_NO_SP2,
		ERR_BAD_CODE,
		ERR_NO_BLANK
	} err_t;

	typedef enum logic [1:0] {
		EV_DATA,
		EV_LINE,
		EV_FINISH
	} event_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  field_idx;
		logic        cr_held;
		logic        line_empty;
		logic        colon_seen;
		logic        skip_blanks;
		code_stage_t code_stage;
		logic        code_neg;
		logic [31:0] code_mag;
		logic        code_ovf;
		err_t        pending_err;
	} hmp_state_t;

	localparam hmp_state_t HMP_STATE_RESET = '{
		phase:       PH_START,
		field_idx:   2'd0,
		cr_held:     1'b0,
		line_empty:  1'b1,
		colon_seen:  1'b0,
		skip_blanks: 1'b0,
		code_stage:  CS_LEAD,
		code_neg:    1'b0,
		code_mag:    32'd0,
		code_ovf:    1'b0,
		pending_err: ERR_OK
	};

	typedef struct packed {
		event_t             event_kind;
		logic [7:0]         data_byte;
		logic [2:0]         field_tag;
		logic               line_kept;
		err_t               error_code;
		logic signed [31:0] status_value;
		logic               last_of_run;
	} hmp_result_t;

	// Outcome of one elementary parsing step: new state and an optional result.
	typedef struct packed {
		hmp_state_t  st;
		logic        emit;
		hmp_result_t res;
	} hmp_dc_t;

	function automatic hmp_result_t data_result(input logic [7:0] c, input logic [2:0] tag);
		hmp_result_t r;
		r = '0;
		r.event_kind = EV_DATA;
		r.data_byte  = c;
		r.field_tag  = tag;
		return r;
	endfunction

	function automatic hmp_state_t code_digit(input hmp_state_t s, input logic [3:0] d);
		hmp_state_t  r;
		logic [35:0] t;
		logic [35:0] limit;
		r = s;
		r.code_stage = CS_DIGITS;
		t = ({4'd0, s.code_mag} << 3) + ({4'd0, s.code_mag} << 1) + {32'd0, d};
		limit = s.code_neg ? CODE_LIMIT_NEG : CODE_LIMIT_POS;
		if (!s.code_ovf) begin
			if (t > limit) begin
				r.code_ovf = 1'b1;
			end else begin
				r.code_mag = t[31:0];
			end
		end
		return r;
	endfunction

	// Status code conversion in the style of stoi.
	function automatic hmp_state_t code_feed(input hmp_state_t s, input logic [7:0] c);
		hmp_state_t r;
		logic       digit;
		logic       blank;
		logic [7:0] dv;
		r = s;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
		dv = c - CH_ZERO;
		unique case (s.code_stage)
			CS_LEAD: begin
				if (blank) begin
					r = s;
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					r.code_neg = (c == CH_MINUS);
					r.code_stage = CS_SIGN;
				end else if (digit) begin
					r = code_digit(s, dv[3:0]);
				end else begin
					r.code_ovf = 1'b1;
					r.code_stage = CS_STOP;
				end
			end
			CS_SIGN: begin
				if (digit) begin
					r = code_digit(s, dv[3:0]);
				end else begin
					r.code_ovf = 1'b1;
					r.code_stage = CS_STOP;
				end
			end
			CS_DIGITS: begin
				if (digit) begin
					r = code_digit(s, dv[3:0]);
				end else begin
					r.code_stage = CS_STOP;
				end
			end
			CS_STOP: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	// One content byte (anything that is not part of a line break).
	function automatic hmp_dc_t data_char(input hmp_state_t s, input logic [7:0] c,
			input logic kind);
		hmp_dc_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.res  = '0;
		unique case (s.phase)
			PH_START: begin
				if (c == CH_SP && s.field_idx < 2'd2) begin
					r.st.field_idx = s.field_idx + 2'd1;
				end else begin
					r.emit = 1'b1;
					r.res  = data_result(c, {1'b0, s.field_idx});
					if (kind && s.field_idx == 2'd1) begin
						r.st = code_feed(s, c);
					end
				end
			end
			PH_HEADERS: begin
				r.st.line_empty = 1'b0;
				if (!s.colon_seen) begin
					if (c == CH_COLON) begin
						r.st.colon_seen  = 1'b1;
						r.st.skip_blanks = 1'b1;
					end else begin
						r.emit = 1'b1;
						r.res  = data_result(c, TAG_NAME);
					end
				end else if (!(s.skip_blanks && (c == CH_SP || c == CH_TAB))) begin
					r.st.skip_blanks = 1'b0;
					r.emit = 1'b1;
					r.res  = data_result(c, TAG_VALUE);
				end
			end
			default: begin
				r.emit = 1'b1;
				r.res  = data_result(c, TAG_BODY);
			end
		endcase
		return r;
	endfunction

	// A CRLF pair closes the current line.
	function automatic hmp_dc_t line_break(input hmp_state_t s, input logic kind);
		hmp_dc_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.res  = '0;
		if (s.phase == PH_START) begin
			if (s.field_idx < 2'd1) begin
				r.st.pending_err = ERR_NO_SP1;
			end else if (s.field_idx < 2'd2) begin
				r.st.pending_err = ERR_NO_SP2;
			end else if (kind && (s.code_ovf || s.code_stage == CS_LEAD
					|| s.code_stage == CS_SIGN)) begin
				r.st.pending_err = ERR_BAD_CODE;
			end
			r.st.phase = PH_HEADERS;
		end else if (s.line_empty) begin
			r.st.phase = PH_BODY;
		end else begin
			r.emit = 1'b1;
			r.res.event_kind = EV_LINE;
			r.res.line_kept  = s.colon_seen;
		end
		r.st.line_empty  = 1'b1;
		r.st.colon_seen  = 1'b0;
		r.st.skip_blanks = 1'b0;
		return r;
	endfunction

endpackage

/* hdl/http_message_byte_parser.sv */
// ----------------------------------------------------------------------------
// HTTP message byte parser
// Parses a request or response one byte at a time into tagged data bytes,
// header line events and a finish event carrying the error code.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is held in the input register, parsed when the
//   result queue has room, and its results are then written to the queue.
// Throughput: one byte per cycle while each byte yields at most one result
//   and out_ready is high; more results of a byte leave the port one by one.
// Reset: arst_n clears the parser state to the start line, empties the result
//   queue and sets message_kind to request mode; no memory clearing pass.
// ----------------------------------------------------------------------------
module http_message_byte_parser import hmp_pkg::*; #(
	parameter int QUEUE_DEPTH = HMP_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel (message_kind).
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	// Byte input channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         byte_in,
	input  logic               end_of_message,
	// Result output channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_kind,
	output logic [7:0]         data_byte,
	output logic [2:0]         field_tag,
	output logic               line_kept,
	output logic [2:0]         error_code,
	output logic signed [31:0] status_value,
	output logic               last_of_run
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Configuration register. The user must write it only with the block idle, so
	// the parser may read it live on every byte; the block does not enforce it.
	logic message_kind_q;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	logic       fire_s1;

	logic [1:0]    res_n;
	hmp_result_t   res [HMP_MAX_RESULTS];
	hmp_result_t   head;
	logic [CW-1:0] q_count;
	logic          space_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_kind_q <= 1'b0;
		end else if (cfg_valid) begin
			message_kind_q <= cfg_data;
		end
	end

	// The parse stage fires only when the queue can absorb the worst case of
	// three results. Counting the current occupancy alone keeps in_ready free
	// of any path from out_ready.
	assign space_ok = (q_count <= CW'(QUEUE_DEPTH - HMP_MAX_RESULTS));
	assign fire_s1  = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eom_s1  <= end_of_message;
		end
	end

	// The parser walks the held carriage return, the byte itself, a carriage
	// return flushed at the end of the message and the finish event, all
	// combinationally, and updates its state on the transaction that fires.
	hmp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire_s1),
		.byte_s1 (byte_s1),
		.eom_s1  (eom_s1),
		.kind    (message_kind_q),
		.res_n   (res_n),
		.res     (res)
	);

	// Results wait in the queue so the input keeps flowing while the output
	// side stalls.
	hmp_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire_s1 ? res_n : 2'd0),
		.push_data (res),
		.pop       (out_valid && out_ready),
		.head      (head),
		.count     (q_count)
	);

	assign out_valid    = (q_count != '0);
	assign event_kind   = head.event_kind;
	assign data_byte    = head.data_byte;
	assign field_tag    = head.field_tag;
	assign line_kept    = head.line_kept;
	assign error_code   = head.error_code;
	assign status_value = head.status_value;
	assign last_of_run  = head.last_of_run;

	// The last byte of a message always closes with a finish event.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && eom_s1) |-> (res_n != 2'd0
			&& res[res_n - 2'd1].event_kind == EV_FINISH))
		else $error("end of message did not produce a finish event");

	// The queue never receives more results than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> (int'(q_count) + int'(res_n) <= QUEUE_DEPTH))
		else $error("result queue overflow");

	// An accepted byte is held in the input register in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted byte lost before parsing");

endmodule

/* hdl/hmp_parser.sv */
// ----------------------------------------------------------------------------
// HTTP message parser core
// Holds the parser state and turns one registered byte into up to three
// results combinationally.
// ----------------------------------------------------------------------------
module hmp_parser import hmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_s1,
	input  logic        eom_s1,
	input  logic        kind,
	output logic [1:0]  res_n,
	output hmp_result_t res [HMP_MAX_RESULTS]
);

	localparam int NUM_SLOTS = 4;

	hmp_state_t state_q;
	hmp_state_t state_d;
	hmp_dc_t    slot [NUM_SLOTS];

	always_comb begin
		hmp_state_t  st;
		logic        do_b;
		logic [1:0]  n;
		hmp_result_t fin;

		st   = state_q;
		do_b = 1'b0;
		fin  = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			slot[k] = '0;
		end

		// Slot 0: held carriage return, either a line break or plain data.
		if (st.phase == PH_BODY) begin
			do_b = 1'b1;
		end else if (st.cr_held) begin
			st.cr_held = 1'b0;
			if (byte_s1 == CH_LF) begin
				slot[0] = line_break(st, kind);
				st = slot[0].st;
			end else begin
				slot[0] = data_char(st, CH_CR, kind);
				st = slot[0].st;
				if (byte_s1 == CH_CR) begin
					st.cr_held = 1'b1;
				end else begin
					do_b = 1'b1;
				end
			end
		end else if (byte_s1 == CH_CR) begin
			st.cr_held = 1'b1;
		end else begin
			do_b = 1'b1;
		end

		// Slot 1: the byte itself.
		if (do_b) begin
			slot[1] = data_char(st, byte_s1, kind);
			st = slot[1].st;
		end

		// Slots 2 and 3: flush a held carriage return, then the finish event.
		if (eom_s1) begin
			if (st.cr_held) begin
				st.cr_held = 1'b0;
				slot[2] = data_char(st, CH_CR, kind);
				st = slot[2].st;
			end
			fin.event_kind = EV_FINISH;
			if (st.pending_err != ERR_OK) begin
				fin.error_code = st.pending_err;
			end else if (st.phase == PH_START) begin
				fin.error_code = ERR_NO_CRLF;
			end else if (st.phase == PH_HEADERS) begin
				fin.error_code = ERR_NO_BLANK;
			end else begin
				fin.error_code = ERR_OK;
			end
			if (kind && st.phase != PH_START && st.pending_err == ERR_OK) begin
				fin.status_value = st.code_neg ? (32'sd0 - $signed(st.code_mag))
					: $signed(st.code_mag);
			end
			slot[3].emit = 1'b1;
			slot[3].res  = fin;
			st = HMP_STATE_RESET;
		end
		state_d = st;

		// Pack the emitted results in order and mark the last one.
		n = 2'd0;
		for (int k = 0; k < HMP_MAX_RESULTS; k++) begin
			res[k] = '0;
		end
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (slot[k].emit && n != 2'd3) begin
				res[n] = slot[k].res;
				n = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			res[n - 2'd1].last_of_run = 1'b1;
		end
		res_n = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HMP_STATE_RESET;
		end else if (step) begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/hmp_result_queue.sv */
// ----------------------------------------------------------------------------
// HTTP message parser result queue
// Small circular buffer that takes up to three results per cycle and hands
// one per cycle to the output channel while the output side pops.
// ----------------------------------------------------------------------------
module hmp_result_queue import hmp_pkg::*; #(
	parameter int DEPTH = HMP_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_n,
	input  hmp_result_t                push_data [HMP_MAX_RESULTS],
	input  logic                       pop,
	output hmp_result_t                head,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	hmp_result_t   mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] k);
		logic [PW:0] sum;
		sum = {1'b0, p} + (PW + 1)'(k);
		if (sum >= (PW + 1)'(DEPTH)) begin
			sum = sum - (PW + 1)'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < HMP_MAX_RESULTS; k++) begin
			if (2'(k) < push_n) begin
				mem[ptr_add(wr_q, 2'(k))] <= push_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= ptr_add(wr_q, push_n);
			rd_q    <= ptr_add(rd_q, {1'b0, pop});
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	assign head  = mem[rd_q];
	assign count = count_q;

endmodule

/* bench/hmp_parse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP message parser checker
// Watches the configuration, byte and result channels of the parser, keeps
// its own copy of the parse state, predicts the events of every accepted
// byte and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module hmp_parse_checker import hmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         byte_in,
	input  logic               end_of_message,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         event_kind,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         field_tag,
	input  logic               line_kept,
	input  logic [2:0]         error_code,
	input  logic signed [31:0] status_value,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 outstanding
);

	typedef struct packed {
		event_t      kind;
		logic [7:0]  dbyte;
		logic [2:0]  tag;
		logic        kept;
		err_t        err;
		logic [31:0] status;
		logic        last;
	} parse_event_t;

	parse_event_t expected_events[$];
	parse_event_t step_events[$];

	// Shadow of the parser state and of the message_kind register.
	logic        kind_reg;
	phase_t      ph;
	logic [1:0]  fidx;
	logic        cr_wait;
	logic        empty_line;
	logic        colon;
	logic        skip_ws;
	code_stage_t cstage;
	logic        cneg;
	logic [31:0] cmag;
	logic        covf;
	err_t        perr;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic clear_parse();
		ph         = PH_START;
		fidx       = 2'd0;
		cr_wait    = 1'b0;
		empty_line = 1'b1;
		colon      = 1'b0;
		skip_ws    = 1'b0;
		cstage     = CS_LEAD;
		cneg       = 1'b0;
		cmag       = 32'd0;
		covf       = 1'b0;
		perr       = ERR_OK;
	endtask

	task automatic put_event(input event_t k, input logic [7:0] b, input logic [2:0] t,
			input logic kept, input err_t e, input logic [31:0] s);
		parse_event_t ev;
		if (step_events.size() < HMP_MAX_RESULTS) begin
			ev.kind   = k;
			ev.dbyte  = b;
			ev.tag    = t;
			ev.kept   = kept;
			ev.err    = e;
			ev.status = s;
			ev.last   = 1'b0;
			step_events = {step_events, ev};
		end
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [63:0] prod;
		logic [63:0] lim;
		cstage = CS_DIGITS;
		if (!covf) begin
			prod = {32'd0, cmag} * 64'd10 + {56'd0, c - CH_ZERO};
			lim  = cneg ? 64'd2147483648 : 64'd2147483647;
			if (prod > lim)
				covf = 1'b1;
			else
				cmag = prod[31:0];
		end
	endtask

	// Status code conversion: blanks, optional sign, digits up to a non-digit.
	task automatic status_feed(input logic [7:0] c);
		logic is_digit;
		logic is_blank;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		is_blank = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
		case (cstage)
			CS_LEAD: begin
				if (is_blank) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					cneg   = (c == CH_MINUS);
					cstage = CS_SIGN;
				end else if (is_digit) begin
					take_digit(c);
				end else begin
					covf   = 1'b1;
					cstage = CS_STOP;
				end
			end
			CS_SIGN: begin
				if (is_digit) begin
					take_digit(c);
				end else begin
					covf   = 1'b1;
					cstage = CS_STOP;
				end
			end
			CS_DIGITS: begin
				if (is_digit)
					take_digit(c);
				else
					cstage = CS_STOP;
			end
			default: begin
			end
		endcase
	endtask

	task automatic content_byte(input logic [7:0] c);
		case (ph)
			PH_START: begin
				if (c == CH_SP && fidx < 2'd2) begin
					fidx = fidx + 2'd1;
				end else begin
					put_event(EV_DATA, c, {1'b0, fidx}, 1'b0, ERR_OK, 32'd0);
					if (kind_reg && fidx == 2'd1)
						status_feed(c);
				end
			end
			PH_HEADERS: begin
				empty_line = 1'b0;
				if (!colon) begin
					if (c == CH_COLON) begin
						colon   = 1'b1;
						skip_ws = 1'b1;
					end else begin
						put_event(EV_DATA, c, TAG_NAME, 1'b0, ERR_OK, 32'd0);
					end
				end else if (!(skip_ws && (c == CH_SP || c == CH_TAB))) begin
					skip_ws = 1'b0;
					put_event(EV_DATA, c, TAG_VALUE, 1'b0, ERR_OK, 32'd0);
				end
			end
			default: begin
				put_event(EV_DATA, c, TAG_BODY, 1'b0, ERR_OK, 32'd0);
			end
		endcase
	endtask

	task automatic close_line();
		if (ph == PH_START) begin
			if (fidx < 2'd1)
				perr = ERR_NO_SP1;
			else if (fidx < 2'd2)
				perr = ERR_NO_SP2;
			else if (kind_reg && (covf || !(cstage == CS_DIGITS || cstage == CS_STOP)))
				perr = ERR_BAD_CODE;
			ph = PH_HEADERS;
		end else if (empty_line) begin
			ph = PH_BODY;
		end else begin
			put_event(EV_LINE, 8'd0, 3'd0, colon, ERR_OK, 32'd0);
		end
		empty_line = 1'b1;
		colon      = 1'b0;
		skip_ws    = 1'b0;
	endtask

	// Predicts the events of one accepted byte and appends them to the store.
	task automatic parse_byte(input logic [7:0] c, input logic last);
		err_t         e;
		logic [31:0]  st;
		step_events.delete();
		if (ph == PH_BODY) begin
			content_byte(c);
		end else if (cr_wait) begin
			cr_wait = 1'b0;
			if (c == CH_LF) begin
				close_line();
			end else begin
				content_byte(CH_CR);
				if (c == CH_CR)
					cr_wait = 1'b1;
				else
					content_byte(c);
			end
		end else if (c == CH_CR) begin
			cr_wait = 1'b1;
		end else begin
			content_byte(c);
		end
		if (last) begin
			if (cr_wait) begin
				cr_wait = 1'b0;
				content_byte(CH_CR);
			end
			if (perr != ERR_OK)
				e = perr;
			else if (ph == PH_START)
				e = ERR_NO_CRLF;
			else if (ph == PH_HEADERS)
				e = ERR_NO_BLANK;
			else
				e = ERR_OK;
			st = 32'd0;
			if (kind_reg && ph != PH_START && perr == ERR_OK)
				st = cneg ? (32'd0 - cmag) : cmag;
			put_event(EV_FINISH, 8'd0, 3'd0, 1'b0, e, st);
			clear_parse();
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
		expected_events = {expected_events, step_events};
	endtask

	// Results are taken before new bytes, since a byte accepted at an edge
	// cannot produce a result at that same edge.
	always @(posedge clk or negedge arst_n) begin
		parse_event_t want;
		if (!arst_n) begin
			clear_parse();
			kind_reg = 1'b0;
			expected_events.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with no event expected",
						event_kind));
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", event_kind, want.kind);
					check_field("data_byte", data_byte, want.dbyte);
					check_field("field_tag", field_tag, want.tag);
					check_field("line_kept", line_kept, want.kept);
					check_field("error_code", error_code, want.err);
					check_field("status_value", status_value, want.status);
					check_field("last_of_run", last_of_run, want.last);
				end
			end
			if (cfg_valid && cfg_ready)
				kind_reg = cfg_data;
			if (in_valid && in_ready)
				parse_byte(byte_in, end_of_message);
			outstanding <= expected_events.size();
		end
	end

endmodule

/* bench/tb_http_message_byte_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP message parser testbench
// Feeds requests and responses byte by byte: a few directed corner cases,
// then randomly built messages, mostly well formed with random content, the
// rest truncated, sprinkled with bare carriage returns or plain noise. The
// checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_http_message_byte_parser import hmp_pkg::*; ();

	// Cycles with no transaction on any channel before the run is abandoned.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int WATCHDOG_LIMIT = 3000;
	// Length of the receiver hold-off that backs the parser up.
	localparam int RX_HOLD = 150;
	// Settling time after the last expected result; a byte passes the input
	// register before it is parsed, so this covers bytes that emit nothing
	// but are still in flight.
	localparam int SETTLE = 4;
	localparam int DRAIN = 10;
	localparam int RANDOM_BYTES = 120;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         byte_in = 8'd0;
	logic               end_of_message = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         event_kind;
	logic [7:0]         data_byte;
	logic [2:0]         field_tag;
	logic               line_kept;
	logic [2:0]         error_code;
	logic signed [31:0] status_value;
	logic               last_of_run;

	int fail_count;
	int outstanding;
	int idle_cycles = 0;

	// Idling controls shared between the sender and the receiver process.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_go = 1'b0;

	logic [7:0] msg_q[$];

	always #10 clk = ~clk;

	http_message_byte_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.data_byte     (data_byte),
		.field_tag     (field_tag),
		.line_kept     (line_kept),
		.error_code    (error_code),
		.status_value  (status_value),
		.last_of_run   (last_of_run)
	);

	hmp_parse_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.data_byte     (data_byte),
		.field_tag     (field_tag),
		.line_kept     (line_kept),
		.error_code    (error_code),
		.status_value  (status_value),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// The watchdog restarts on every transaction of any channel, so it only
	// fires when the parser has truly locked up or results never arrive.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver. It drops ready with a chance of 30 in a hundred while idling
	// is enabled. When the sender asks for a hold-off, ready stays low for
	// the RX_HOLD hold-off, counted here, so the result queue fills and the
	// parser stops taking bytes.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 99) < 30) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one byte and waits for its transaction. A gap, when one is
	// drawn, lowers valid first; otherwise valid simply stays high.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (tx_gaps && $urandom_range(0, 99) < 30) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		byte_in        <= b;
		end_of_message <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sends the assembled message with end_of_message on its final byte.
	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++)
			send_byte(msg_q[i], i == msg_q.size() - 1);
		msg_q.delete();
	endtask

	// The sender goes quiet until every predicted result has come out.
	// The first edge is taken before looking, because the count published
	// by the checker is registered and lags the last byte transaction.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// The register is only written with the parser idle, after its last
	// byte has had time to leave the pipeline.
	task automatic set_kind(input logic k);
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Appends one byte to the message under construction.
	task automatic add_byte(input logic [7:0] b);
		msg_q = {msg_q, b};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	function automatic logic [7:0] digit_char();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Token bytes are mostly letters, with the odd delimiter, control byte
	// or arbitrary value mixed in.
	function automatic logic [7:0] token_char();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 13)
			return 8'h61 + 8'($urandom_range(0, 25));
		case (pick)
			13: return digit_char();
			14: return CH_COLON;
			15: return CH_TAB;
			16: return CH_CR;
			17: return CH_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 6))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_SP;
			3: return CH_COLON;
			4: return CH_TAB;
			5: return 8'h61 + 8'($urandom_range(0, 25));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_token(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) add_byte(token_char());
	endtask

	task automatic add_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) add_byte(digit_char());
	endtask

	// Status codes: plain three-digit codes, leading blanks, signs, values
	// around the 32-bit limits, an empty code and codes that are not numbers.
	task automatic add_status();
		case ($urandom_range(0, 7))
			0, 1: add_digits(3, 3);
			2: begin
				add_byte(8'($urandom_range(9, 13)));
				add_digits(1, 3);
			end
			3: begin
				add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				add_digits(0, 3);
			end
			4: begin
				case ($urandom_range(0, 5))
					0: add_text("2147483647");
					1: add_text("-2147483648");
					2: add_text("2147483648");
					3: add_text("-2147483649");
					4: add_text("4294967296");
					default: add_text("+0");
				endcase
			end
			5: begin
			end
			6: add_token(1, 2);
			default: begin
				add_digits(1, 2);
				add_byte(8'h61 + 8'($urandom_range(0, 25)));
			end
		endcase
	endtask

	// Builds one message. Most are well formed: a start line split by two
	// spaces, a couple of header lines, a blank line and a short body. Some
	// are cut short, some carry stray carriage returns, some are pure noise.
	task automatic build_message(input logic k);
		int style;
		int cut;
		style = $urandom_range(0, 9);
		msg_q.delete();
		if (style == 9) begin
			repeat ($urandom_range(1, 6)) add_byte(noise_char());
		end else begin
			add_token(1, 3);
			if ($urandom_range(0, 7) != 0)
				add_byte(CH_SP);
			if (k)
				add_status();
			else
				add_token(1, 4);
			if ($urandom_range(0, 7) != 0)
				add_byte(CH_SP);
			add_token(0, 3);
			// Spaces past the second one belong to the third start field.
			if ($urandom_range(0, 3) == 0) begin
				add_byte(CH_SP);
				add_token(1, 2);
			end
			add_crlf();
			repeat ($urandom_range(0, 2)) begin
				add_token(0, 3);
				// A header line without a colon is reported as not kept.
				if ($urandom_range(0, 4) != 0)
					add_byte(CH_COLON);
				repeat ($urandom_range(0, 2))
					add_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
				add_token(0, 3);
				add_crlf();
			end
			add_crlf();
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
			if (style == 8) begin
				cut = $urandom_range(1, msg_q.size());
				while (msg_q.size() > cut)
					void'(msg_q.pop_back());
			end else if (style == 7) begin
				repeat ($urandom_range(1, 2))
					msg_q.insert($urandom_range(0, msg_q.size() - 1), CH_CR);
			end
		end
	endtask

	initial begin
		int random_bytes;
		int phase_no;
		logic k;
		random_bytes = 0;
		phase_no = 0;

		// Reset starts asserted and is released on a clock edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part in request mode. A lone 0xFF byte ends a message
		// that never saw a line break. Two carriage returns at the end give
		// the most results one byte can cause: the first is released as data
		// by the second, the second is flushed by the end of the message,
		// then the finish event. A bare CRLF is a start line with no space.
		set_kind(1'b0);
		add_byte(8'hFF);
		send_message();
		add_byte(CH_CR);
		add_byte(CH_CR);
		send_message();
		add_crlf();
		send_message();

		// Response mode: an empty first field, the most negative status code,
		// no headers and a message that ends on the blank line.
		set_kind(1'b1);
		add_text(" -2147483648 ");
		add_crlf();
		add_crlf();
		send_message();

		// Random phases. Each one starts with the sender paused until every
		// expected result is out, then writes the register. The second phase
		// runs with no idling at all and the third asks for the long receiver
		// hold-off while the sender keeps offering bytes.
		while (phase_no < 3 || random_bytes < RANDOM_BYTES) begin
			if (phase_no == 0)
				k = 1'b0;
			else if (phase_no == 1)
				k = 1'b1;
			else
				k = 1'($urandom_range(0, 1));
			set_kind(k);
			tx_gaps = (phase_no != 1);
			rx_gaps = (phase_no != 1);
			if (phase_no == 2)
				hold_go = 1'b1;
			repeat (2) begin
				build_message(k);
				random_bytes += msg_q.size();
				send_message();
			end
			phase_no++;
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
